@@ design/bfpu_pkg.sv @@
// ----------------------------------------------------------------------------
// bfpu_pkg: shared types and constants of the bit field pack / unpack buffer
// Operation codes, status codes, register indexes, store geometry and the
// request word that the sequencer hands to the byte store.
// ----------------------------------------------------------------------------
package bfpu_pkg;

  // Store geometry
  localparam int BUFFER_BYTES = 256;
  localparam int STORE_AW     = $clog2(BUFFER_BYTES);
  localparam int MAX_BITS     = BUFFER_BYTES * 8;

  // Operation codes on func
  localparam logic [2:0] FN_WRITE   = 3'd0;
  localparam logic [2:0] FN_READ    = 3'd1;
  localparam logic [2:0] FN_ALIGN   = 3'd2;
  localparam logic [2:0] FN_LOAD    = 3'd3;
  localparam logic [2:0] FN_FETCH   = 3'd4;
  localparam logic [2:0] FN_RESTART = 3'd5;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_READ_ONLY = 2'd1;
  localparam logic [1:0] ST_LIMIT     = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_READ_ONLY  = 2'd0;
  localparam logic [1:0] REG_DATA_BYTES = 2'd1;

  // Request word from the sequencer to the byte store
  typedef struct packed {
    logic                rd_en;
    logic [STORE_AW-1:0] rd_addr;
    logic                wr_en;
    logic [STORE_AW-1:0] wr_addr;
    logic [7:0]          wr_data;
  } store_req_t;

endpackage

@@ design/bit_field_pack_unpack_buffer_core.sv @@
// ----------------------------------------------------------------------------
// bit_field_pack_unpack_buffer_core: bit field pack / unpack buffer
// Packs and unpacks fields of 1 to 64 bits at a running bit cursor in a
// 256-byte store, plus align, raw byte load / fetch and restart.
// ----------------------------------------------------------------------------
// Issue a word with start while busy is low; its result appears for exactly
// one cycle with done high and cannot be held off, so capture it then. A field
// write or read of w bits at cursor offset o = cursor mod 8 touches
// K+1 store bytes, K = (o+w-1)/8, up to nine for a 64-bit field. Each byte
// is read through the store's byte-wide read port and, for a write, merged
// and written back through its write port; a read takes an extra flush step
// when its last chunk lies wholly in the last byte touched. Align, restart,
// load byte, zero-width, unused and refused or out-of-limit items finish in
// the decode step, fetch byte in the fetch step after it. A new word may be
// issued in the cycle done is high. The store comes out of reset reading all
// zeros at once; there is no clearing pass.
// Configuration writes are always taken (cfg_ready is tied high) and must be
// made only while the block is idle.
module bit_field_pack_unpack_buffer_core import bfpu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // command channel
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  func,
  input  logic [63:0] value,
  input  logic [6:0]  width,
  input  logic [7:0]  byte_index,
  input  logic [7:0]  byte_data,
  // result channel
  output logic        done,
  output logic [63:0] read_value,
  output logic [7:0]  fetched_byte,
  output logic [1:0]  status,
  output logic [11:0] bit_position,
  output logic [8:0]  used_bytes,
  // configuration channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_RMW,
    S_FLUSH,
    S_FETCH
  } state_t;

  state_t              state;

  // configuration and cursor
  logic                read_only;
  logic [8:0]          data_bytes;
  logic [11:0]         cursor;

  // latched command word
  logic [2:0]          func_q;
  logic [63:0]         value_q;
  logic [6:0]          w_q;
  logic [7:0]          idx_q;
  logic [7:0]          bdata_q;
  logic                op_write;

  // field walk state
  logic [STORE_AW-1:0] base;
  logic [2:0]          o;
  logic [3:0]          kl;
  logic [3:0]          iss;
  logic [3:0]          prc;
  logic                rd_pend;
  logic [7:0]          prev_sb;
  logic [7:0]          mprev;

  // result registers
  logic [63:0]         rv;
  logic [7:0]          fetched;
  logic [1:0]          stat;

  // decode helpers
  logic [8:0]          lim_bytes;
  logic [12:0]         lim_bits;
  logic [12:0]         end_bits;
  logic [12:0]         align_next;
  logic [9:0]          next_byte;
  logic [6:0]          wm1;
  logic [2:0]          jl;
  logic [2:0]          ps;
  logic [6:0]          span;
  logic                idx_ok;
  logic [11:0]         cursor_up;

  // datapath
  logic [7:0]          sel_b;
  logic [7:0]          cur_sb;
  logic [7:0]          f_hi;
  logic [7:0]          f_lo;
  logic [3:0]          f_amt;
  logic [7:0]          fo;
  logic [2:0]          ej;
  logic [7:0]          adj;
  logic [7:0]          rd_data;
  store_req_t          store_req;

  assign cfg_ready = 1'b1;
  assign busy      = (state != S_IDLE);

  // Bound the cursor and derive the field geometry
  assign lim_bytes  = (read_only && (data_bytes < 9'(BUFFER_BYTES))) ? data_bytes
                                                                    : 9'(BUFFER_BYTES);
  assign lim_bits   = {1'b0, lim_bytes, 3'b000};
  assign end_bits   = {1'b0, cursor} + {6'b0, w_q};
  assign next_byte  = {1'b0, cursor[11:3]} + 10'd1;
  assign align_next = {next_byte, 3'b000};
  assign wm1        = w_q - 7'd1;
  assign jl         = wm1[5:3];
  assign ps         = ~wm1[2:0];
  assign span       = {4'b0, cursor[2:0]} + {1'b0, wm1[5:0]};
  assign idx_ok     = ({1'b0, idx_q} < 9'(BUFFER_BYTES));
  assign cursor_up  = cursor + 12'd7;

  // Form the stream byte being packed: chunks in order, last one left-justified
  assign sel_b = value_q[{prc[2:0], 3'b000} +: 8];
  always_comb begin
    if (prc > {1'b0, jl}) begin
      cur_sb = 8'h00;
    end else if (prc[2:0] == jl) begin
      cur_sb = sel_b << ps;
    end else begin
      cur_sb = sel_b;
    end
  end

  // Steer the shared funnel
  always_comb begin
    if (state == S_FLUSH) begin
      f_hi  = mprev;
      f_lo  = 8'h00;
      f_amt = 4'd8 - {1'b0, o};
    end else if (op_write) begin
      f_hi  = prev_sb;
      f_lo  = cur_sb;
      f_amt = {1'b0, o};
    end else begin
      f_hi  = mprev;
      f_lo  = rd_data;
      f_amt = 4'd8 - {1'b0, o};
    end
  end

  bfpu_funnel u_funnel (
    .hi  (f_hi),
    .lo  (f_lo),
    .amt (f_amt),
    .y   (fo)
  );

  // Right-justify the last unpacked chunk
  assign ej  = (state == S_FLUSH) ? kl[2:0] : 3'(prc - 4'd1);
  assign adj = (ej == jl) ? (fo >> ps) : fo;

  // Drive store requests
  always_comb begin
    store_req = '0;
    unique case (state)
      S_DECODE: begin
        if (func_q == FN_LOAD && idx_ok) begin
          store_req.wr_en   = 1'b1;
          store_req.wr_addr = STORE_AW'(idx_q);
          store_req.wr_data = bdata_q;
        end
        if (func_q == FN_FETCH && idx_ok) begin
          store_req.rd_en   = 1'b1;
          store_req.rd_addr = STORE_AW'(idx_q);
        end
      end
      S_RMW: begin
        store_req.rd_en   = (iss <= kl);
        store_req.rd_addr = base + STORE_AW'(iss);
        store_req.wr_en   = op_write && rd_pend;
        store_req.wr_addr = base + STORE_AW'(prc);
        store_req.wr_data = rd_data | fo;
      end
      default: begin
        store_req = '0;
      end
    endcase
  end

  bfpu_store u_store (
    .clk     (clk),
    .rst     (rst),
    .req     (store_req),
    .rd_data (rd_data)
  );

  // Sequence one word at a time
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      done       <= 1'b0;
      rd_pend    <= 1'b0;
      cursor     <= '0;
      read_only  <= 1'b0;
      data_bytes <= '0;
    end else begin
      done    <= 1'b0;
      rd_pend <= 1'b0;

      // take configuration words; other indexes are dropped
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_READ_ONLY) begin
          read_only <= cfg_data[0];
        end else if (cfg_index == REG_DATA_BYTES) begin
          data_bytes <= cfg_data;
        end
      end

      unique case (state)
        S_IDLE: begin
          if (start) begin
            func_q   <= func;
            value_q  <= value;
            w_q      <= (width > 7'd64) ? 7'd64 : width;
            idx_q    <= byte_index;
            bdata_q  <= byte_data;
            op_write <= (func == FN_WRITE);
            rv       <= '0;
            fetched  <= '0;
            stat     <= ST_OK;
            state    <= S_DECODE;
          end
        end

        S_DECODE: begin
          // results that finish here go out next cycle
          done  <= 1'b1;
          state <= S_IDLE;
          base  <= STORE_AW'(cursor >> 3);
          o     <= cursor[2:0];
          kl    <= span[6:3];
          iss   <= '0;
          prc   <= '0;
          prev_sb <= '0;
          mprev   <= '0;
          unique case (func_q)
            FN_WRITE: begin
              if (read_only) begin
                stat <= ST_READ_ONLY;
              end else if (w_q == 7'd0) begin
                stat <= ST_OK;
              end else if (end_bits > lim_bits) begin
                stat <= ST_LIMIT;
              end else begin
                cursor <= end_bits[11:0];
                done   <= 1'b0;
                state  <= S_RMW;
              end
            end
            FN_READ: begin
              if (w_q == 7'd0) begin
                stat <= ST_OK;
              end else if (end_bits > lim_bits) begin
                stat <= ST_LIMIT;
              end else begin
                cursor <= end_bits[11:0];
                done   <= 1'b0;
                state  <= S_RMW;
              end
            end
            FN_ALIGN: begin
              if (align_next > lim_bits) begin
                stat <= ST_LIMIT;
              end else begin
                cursor <= align_next[11:0];
              end
            end
            FN_LOAD: begin
              if (!idx_ok) begin
                stat <= ST_LIMIT;
              end
            end
            FN_FETCH: begin
              if (!idx_ok) begin
                stat <= ST_LIMIT;
              end else begin
                done  <= 1'b0;
                state <= S_FETCH;
              end
            end
            FN_RESTART: begin
              cursor <= '0;
            end
            default: begin
              stat <= ST_OK;
            end
          endcase
        end

        S_RMW: begin
          // issue the next byte read
          if (iss <= kl) begin
            iss     <= iss + 4'd1;
            rd_pend <= 1'b1;
          end
          // merge or gather the byte that just came back
          if (rd_pend) begin
            prc <= prc + 4'd1;
            if (op_write) begin
              prev_sb <= cur_sb;
            end else begin
              mprev <= rd_data;
              if (prc != 4'd0) begin
                rv[{ej, 3'b000} +: 8] <= adj;
              end
            end
            if (prc == kl) begin
              if (!op_write && ({1'b0, jl} == kl)) begin
                state <= S_FLUSH;
              end else begin
                done  <= 1'b1;
                state <= S_IDLE;
              end
            end
          end
        end

        S_FLUSH: begin
          // gather the last chunk from the last byte alone
          rv[{ej, 3'b000} +: 8] <= adj;
          done  <= 1'b1;
          state <= S_IDLE;
        end

        S_FETCH: begin
          fetched <= rd_data;
          done    <= 1'b1;
          state   <= S_IDLE;
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Present the result word
  assign read_value   = rv;
  assign fetched_byte = fetched;
  assign status       = stat;
  assign bit_position = cursor;
  assign used_bytes   = cursor_up[11:3];

  // Result strobes only once the sequencer is back to idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("done raised while busy");

  // An accepted word makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  // The store is written only on behalf of a word in flight
  a_write_busy: assert property (@(posedge clk) disable iff (rst)
    store_req.wr_en |-> busy)
    else $error("store written while idle");

  // The cursor never passes the end of the store
  a_cursor_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> (bit_position <= 12'(MAX_BITS)))
    else $error("bit position beyond store");

  // Refused or out-of-limit words return no data
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_OK) |-> (read_value == 64'd0 && fetched_byte == 8'd0))
    else $error("data returned on a failed word");

endmodule

@@ design/bfpu_funnel.sv @@
// ----------------------------------------------------------------------------
// bfpu_funnel: shared byte funnel shifter
// Shifts the 16-bit pair {hi, lo} right by 0 to 8 bits and returns the low
// byte. Serves both packing (split a stream byte over two store bytes) and
// unpacking (gather a stream byte from two store bytes).
// ----------------------------------------------------------------------------
module bfpu_funnel import bfpu_pkg::*; (
  input  logic [7:0] hi,
  input  logic [7:0] lo,
  input  logic [3:0] amt,
  output logic [7:0] y
);

  logic [15:0] shifted;

  // Shift the pair and keep the low byte
  assign shifted = {hi, lo} >> amt;
  assign y       = shifted[7:0];

endmodule

@@ design/bfpu_store.sv @@
// ----------------------------------------------------------------------------
// bfpu_store: byte store with per-entry valid bits
// One write and one read port per cycle, read data registered. An entry never
// written since reset reads as zero, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module bfpu_store import bfpu_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  store_req_t req,
  output logic [7:0] rd_data
);

  logic [7:0]              mem [BUFFER_BYTES];
  logic [BUFFER_BYTES-1:0] vld;
  logic [7:0]              mem_q;
  logic                    vld_q;

  // Track written entries; reset clears all at once
  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      vld_q <= 1'b0;
    end else begin
      if (req.wr_en) begin
        vld[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        vld_q <= vld[req.rd_addr];
      end
    end
  end

  // Write and read the array
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      mem_q <= mem[req.rd_addr];
    end
  end

  // Drop stale contents of unwritten entries
  assign rd_data = vld_q ? mem_q : 8'h00;

endmodule

@@ tb/tb_bit_field_pack_unpack_buffer_core.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bit_field_pack_unpack_buffer_core: self-checking bench for the field buffer
// Drives command words and register writes from a queue, with random sender
// gaps. A shadow copy of the byte store, bit cursor and registers predicts
// each result; the monitor compares every strobed result field by field.
// ----------------------------------------------------------------------------
module tb_bit_field_pack_unpack_buffer_core;
  import bfpu_pkg::*;

  // Operation codes the block leaves unused
  localparam logic [2:0] FN_SPARE_LO = 3'd6;
  localparam logic [2:0] FN_SPARE_HI = 3'd7;

  // One queued word: a command, or a register write when is_cfg is set
  typedef struct {
    bit          is_cfg;
    logic [1:0]  reg_idx;
    logic [8:0]  reg_data;
    logic [2:0]  func;
    logic [63:0] value;
    logic [6:0]  width;
    logic [7:0]  byte_index;
    logic [7:0]  byte_data;
    int          gap;
  } buf_word_t;

  typedef struct packed {
    logic [63:0] read_value;
    logic [7:0]  fetched_byte;
    logic [1:0]  status;
    logic [11:0] bit_position;
    logic [8:0]  used_bytes;
  } field_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  func = FN_RESTART;
  logic [63:0] value = '0;
  logic [6:0]  width = '0;
  logic [7:0]  byte_index = '0;
  logic [7:0]  byte_data = '0;
  logic        done;
  logic [63:0] read_value;
  logic [7:0]  fetched_byte;
  logic [1:0]  status;
  logic [11:0] bit_position;
  logic [8:0]  used_bytes;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = REG_READ_ONLY;
  logic [8:0]  cfg_data = '0;

  buf_word_t     pending_words[$];
  field_result_t expected_results[$];

  // Shadow state of the buffer
  logic [7:0]  shadow_bytes [BUFFER_BYTES];
  int unsigned shadow_cursor = 0;
  logic        shadow_read_only = 1'b0;
  logic [8:0]  shadow_data_bytes = '0;

  int  err_count = 0;
  int  in_flight = 0;
  int  stim_count = 0;
  int  gap_count = 0;
  bit  idle_bursty = 1'b0;

  bit_field_pack_unpack_buffer_core u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .func         (func),
    .value        (value),
    .width        (width),
    .byte_index   (byte_index),
    .byte_data    (byte_data),
    .done         (done),
    .read_value   (read_value),
    .fetched_byte (fetched_byte),
    .status       (status),
    .bit_position (bit_position),
    .used_bytes   (used_bytes),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #10 clk = ~clk;

  initial begin
    foreach (shadow_bytes[i]) shadow_bytes[i] = 8'h00;
  end

  // Cursor bound in bits for the current register setting
  function automatic int unsigned cursor_limit();
    int unsigned nbytes;
    nbytes = BUFFER_BYTES;
    if (shadow_read_only && shadow_data_bytes < BUFFER_BYTES) nbytes = shadow_data_bytes;
    return nbytes * 8;
  endfunction

  // Apply one command to the shadow state and return the result it produces
  function automatic field_result_t predict_buffer_op(input logic [2:0] op,
                                                      input logic [63:0] fval,
                                                      input logic [6:0] fwidth,
                                                      input logic [7:0] bidx,
                                                      input logic [7:0] bdata);
    field_result_t res;
    int unsigned   w, i, k, n, nxt, pos;
    logic [7:0]    chunk;
    res = '0;
    w = fwidth;
    if (w > 64) w = 64;
    case (op)
      FN_WRITE: begin
        if (shadow_read_only) begin
          res.status = ST_READ_ONLY;
        end else if (w == 0) begin
        end else if (shadow_cursor + w > cursor_limit()) begin
          res.status = ST_LIMIT;
        end else begin
          // OR each chunk in, most significant bit first
          for (i = 0; i < w; i += 8) begin
            n = (w - i < 8) ? (w - i) : 8;
            chunk = fval[i +: 8] & (8'hff >> (8 - n));
            for (k = n; k > 0; k--) begin
              pos = shadow_cursor;
              if (chunk[k-1]) shadow_bytes[pos >> 3][7 - (pos & 7)] = 1'b1;
              shadow_cursor++;
            end
          end
        end
      end
      FN_READ: begin
        if (w == 0) begin
        end else if (shadow_cursor + w > cursor_limit()) begin
          res.status = ST_LIMIT;
        end else begin
          for (i = 0; i < w; i += 8) begin
            n = (w - i < 8) ? (w - i) : 8;
            chunk = 8'h00;
            for (k = 0; k < n; k++) begin
              pos = shadow_cursor;
              chunk = {chunk[6:0], shadow_bytes[pos >> 3][7 - (pos & 7)]};
              shadow_cursor++;
            end
            res.read_value = res.read_value | (64'(chunk) << i);
          end
        end
      end
      FN_ALIGN: begin
        nxt = shadow_cursor + (8 - (shadow_cursor & 7));
        if (nxt > cursor_limit()) res.status = ST_LIMIT;
        else shadow_cursor = nxt;
      end
      FN_LOAD:    shadow_bytes[bidx] = bdata;
      FN_FETCH:   res.fetched_byte = shadow_bytes[bidx];
      FN_RESTART: shadow_cursor = 0;
      default: begin
      end
    endcase
    res.bit_position = 12'(shadow_cursor);
    res.used_bytes   = 9'((shadow_cursor + 7) >> 3);
    return res;
  endfunction

  // Driver: issue queued words, predict each accepted command
  always @(posedge clk) begin : drive_words
    logic      nxt_start;
    logic      nxt_cfg;
    buf_word_t w;
    if (rst) begin
      start     <= 1'b0;
      cfg_valid <= 1'b0;
    end else begin
      nxt_start = start;
      nxt_cfg   = cfg_valid;
      if (start && !busy) begin
        expected_results.push_back(predict_buffer_op(func, value, width,
                                                     byte_index, byte_data));
        in_flight++;
        nxt_start = 1'b0;
      end
      if (done) in_flight--;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_READ_ONLY) shadow_read_only = cfg_data[0];
        else if (cfg_index == REG_DATA_BYTES) shadow_data_bytes = cfg_data;
        nxt_cfg = 1'b0;
      end
      // Pick the next word once nothing is held on either channel
      if (!nxt_start && !nxt_cfg && pending_words.size() != 0) begin
        w = pending_words[0];
        if (w.is_cfg) begin
          // Hold register writes until the block has drained
          if (in_flight == 0 && !busy) begin
            cfg_index <= w.reg_idx;
            cfg_data  <= w.reg_data;
            nxt_cfg = 1'b1;
            void'(pending_words.pop_front());
          end
        end else if (gap_count < w.gap) begin
          gap_count++;
        end else begin
          func       <= w.func;
          value      <= w.value;
          width      <= w.width;
          byte_index <= w.byte_index;
          byte_data  <= w.byte_data;
          nxt_start = 1'b1;
          gap_count = 0;
          void'(pending_words.pop_front());
        end
      end
      start     <= nxt_start;
      cfg_valid <= nxt_cfg;
    end
  end

  // Monitor: compare each strobed result with the oldest prediction
  always @(posedge clk) begin : check_results
    field_result_t exp_res;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        $error("result with no word outstanding: bit_position %0d", bit_position);
        err_count++;
      end else begin
        exp_res = expected_results.pop_front();
        if (read_value !== exp_res.read_value) begin
          $error("read_value: expected %h, got %h", exp_res.read_value, read_value);
          err_count++;
        end
        if (fetched_byte !== exp_res.fetched_byte) begin
          $error("fetched_byte: expected %h, got %h", exp_res.fetched_byte, fetched_byte);
          err_count++;
        end
        if (status !== exp_res.status) begin
          $error("status: expected %0d, got %0d", exp_res.status, status);
          err_count++;
        end
        if (bit_position !== exp_res.bit_position) begin
          $error("bit_position: expected %0d, got %0d", exp_res.bit_position, bit_position);
          err_count++;
        end
        if (used_bytes !== exp_res.used_bytes) begin
          $error("used_bytes: expected %0d, got %0d", exp_res.used_bytes, used_bytes);
          err_count++;
        end
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [7:0] rand8();
    return 8'($urandom_range(0, 255));
  endfunction

  // Field widths lean short, with the full 64 bits now and then
  function automatic logic [6:0] rand_width();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 5) return 7'($urandom_range(1, 12));
    if (r < 8) return 7'($urandom_range(13, 40));
    return 7'($urandom_range(41, 64));
  endfunction

  task automatic add_cmd(input logic [2:0] op, input logic [63:0] fval,
                         input logic [6:0] fwidth, input logic [7:0] bidx,
                         input logic [7:0] bdata);
    buf_word_t w;
    w = '{default: '0};
    w.func       = op;
    w.value      = fval;
    w.width      = fwidth;
    w.byte_index = bidx;
    w.byte_data  = bdata;
    // Bursty and quiet stretches alternate every 16 words
    if (idle_bursty && ((stim_count / 16) % 2 == 0) && $urandom_range(0, 2) == 0)
      w.gap = $urandom_range(1, 11);
    if (op != FN_SPARE_LO && op != FN_SPARE_HI) stim_count++;
    pending_words.push_back(w);
  endtask

  task automatic add_cfg(input logic [1:0] idx, input logic [8:0] data);
    buf_word_t w;
    w = '{default: '0};
    w.is_cfg   = 1'b1;
    w.reg_idx  = idx;
    w.reg_data = data;
    pending_words.push_back(w);
  endtask

  // Pack a run of fields, then rewind and unpack them with the same widths
  task automatic add_write_read_record();
    int         nf, total, f, b;
    logic [6:0] fw [8];
    bit         pad [8];
    nf = $urandom_range(1, 8);
    total = 0;
    for (f = 0; f < nf; f++) begin
      fw[f]  = rand_width();
      pad[f] = ($urandom_range(0, 3) == 0);
      total += fw[f] + (pad[f] ? 8 : 0);
    end
    add_cmd(FN_RESTART, rand64(), rand_width(), rand8(), rand8());
    if ($urandom_range(0, 1) == 1)
      for (b = 0; b <= total / 8 && b < BUFFER_BYTES; b++)
        add_cmd(FN_LOAD, rand64(), rand_width(), 8'(b), 8'h00);
    for (f = 0; f < nf; f++) begin
      add_cmd(FN_WRITE, rand64(), fw[f], rand8(), rand8());
      if (pad[f]) add_cmd(FN_ALIGN, rand64(), rand_width(), rand8(), rand8());
    end
    add_cmd(FN_RESTART, rand64(), rand_width(), rand8(), rand8());
    for (f = 0; f < nf; f++) begin
      add_cmd(FN_READ, rand64(), fw[f], rand8(), rand8());
      if (pad[f]) add_cmd(FN_ALIGN, rand64(), rand_width(), rand8(), rand8());
    end
    if ($urandom_range(0, 1) == 1)
      add_cmd(FN_FETCH, rand64(), rand_width(), 8'($urandom_range(0, total / 8)), rand8());
  endtask

  // Load raw bytes, rewind and unpack fields from them
  task automatic add_read_only_record();
    int nbytes, nf, b, f;
    nbytes = $urandom_range(1, 24);
    for (b = 0; b < nbytes; b++) add_cmd(FN_LOAD, rand64(), rand_width(), 8'(b), rand8());
    add_cmd(FN_RESTART, rand64(), rand_width(), rand8(), rand8());
    nf = $urandom_range(1, 8);
    for (f = 0; f < nf; f++) begin
      case ($urandom_range(0, 7))
        0:       add_cmd(FN_ALIGN, rand64(), rand_width(), rand8(), rand8());
        1:       add_cmd(FN_WRITE, rand64(), rand_width(), rand8(), rand8());
        default: add_cmd(FN_READ, rand64(), rand_width(), rand8(), rand8());
      endcase
    end
    add_cmd(FN_FETCH, rand64(), rand_width(), 8'($urandom_range(0, nbytes)), rand8());
  endtask

  // Set both registers, then mix records and noise until the phase share is met
  task automatic run_phase(input logic ro, input logic [8:0] db, input int share);
    int goal;
    add_cfg(REG_READ_ONLY, 9'(ro));
    add_cfg(REG_DATA_BYTES, db);
    goal = stim_count + share;
    while (stim_count < goal) begin
      if ($urandom_range(0, 3) == 0)
        add_cmd(3'($urandom_range(0, 7)), rand64(),
                ($urandom_range(0, 1) == 1) ? 7'($urandom_range(0, 127)) : rand_width(),
                rand8(), rand8());
      else if (ro)
        add_read_only_record();
      else
        add_write_read_record();
    end
  endtask

  // Stimulus, drain and verdict
  initial begin : run_test
    int i;
    // Directed: field extremes, saturation, zero width, align, raw bytes
    add_cmd(FN_WRITE, '1, 7'd64, 8'd0, 8'd0);
    add_cmd(FN_WRITE, 64'h5, 7'd3, 8'd0, 8'd0);
    add_cmd(FN_WRITE, '1, 7'd127, 8'd0, 8'd0);
    add_cmd(FN_WRITE, '1, 7'd0, 8'd0, 8'd0);
    add_cmd(FN_ALIGN, '0, 7'd0, 8'd0, 8'd0);
    add_cmd(FN_ALIGN, '0, 7'd0, 8'd0, 8'd0);
    add_cmd(FN_WRITE, 64'h8000_0000_0000_0001, 7'd64, 8'd0, 8'd0);
    add_cmd(FN_LOAD, '0, 7'd0, 8'd255, 8'hff);
    add_cmd(FN_FETCH, '0, 7'd0, 8'd255, 8'd0);
    add_cmd(FN_RESTART, '0, 7'd0, 8'd0, 8'd0);
    add_cmd(FN_READ, '0, 7'd64, 8'd0, 8'd0);
    add_cmd(FN_READ, '0, 7'd3, 8'd0, 8'd0);
    add_cmd(FN_READ, '0, 7'd127, 8'd0, 8'd0);
    add_cmd(FN_READ, '0, 7'd0, 8'd0, 8'd0);
    add_cmd(FN_SPARE_LO, '1, 7'd64, 8'd255, 8'hff);
    add_cmd(FN_SPARE_HI, '1, 7'd64, 8'd255, 8'hff);
    // Directed, read-only with a two byte bound: refusal and limit hits
    add_cfg(REG_READ_ONLY, 9'd1);
    add_cfg(REG_DATA_BYTES, 9'd2);
    add_cmd(FN_WRITE, '1, 7'd8, 8'd0, 8'd0);
    add_cmd(FN_RESTART, '0, 7'd0, 8'd0, 8'd0);
    add_cmd(FN_READ, '0, 7'd16, 8'd0, 8'd0);
    add_cmd(FN_READ, '0, 7'd1, 8'd0, 8'd0);
    add_cmd(FN_ALIGN, '0, 7'd0, 8'd0, 8'd0);
    add_cmd(FN_RESTART, '0, 7'd0, 8'd0, 8'd0);
    add_cmd(FN_ALIGN, '0, 7'd0, 8'd0, 8'd0);
    add_cmd(FN_LOAD, '0, 7'd0, 8'd0, 8'h00);
    add_cmd(FN_FETCH, '0, 7'd0, 8'd0, 8'd0);

    // Random phases over several register settings
    idle_bursty = 1'b1;
    run_phase(1'b0, 9'd0, 55);
    // Fill the whole store with 64-bit fields, then run into the bound
    add_cmd(FN_RESTART, rand64(), rand_width(), rand8(), rand8());
    for (i = 0; i < 33; i++) add_cmd(FN_WRITE, rand64(), 7'd64, rand8(), rand8());
    add_cmd(FN_WRITE, rand64(), 7'd1, rand8(), rand8());
    add_cmd(FN_ALIGN, rand64(), rand_width(), rand8(), rand8());
    add_cmd(FN_READ, rand64(), 7'd1, rand8(), rand8());
    run_phase(1'b1, 9'd256, 55);
    run_phase(1'b1, 9'($urandom_range(1, 24)), 45);
    run_phase(1'b0, 9'd511, 55);
    run_phase(1'b1, 9'd511, 45);
    run_phase(1'b1, 9'd0, 15);
    // Back to back to the end
    idle_bursty = 1'b0;
    run_phase(1'b0, 9'($urandom_range(0, 511)), 45);

    // Let the queue empty, then collect the stragglers
    @(negedge clk);
    while (pending_words.size() != 0 || start || cfg_valid) @(negedge clk);
    for (i = 0; i < 5000 && expected_results.size() != 0; i++) @(negedge clk);
    repeat (20) @(negedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Hold reset from time zero, then release it
  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

@@ filelist.f @@
design/bfpu_pkg.sv
design/bfpu_funnel.sv
design/bfpu_store.sv
design/bit_field_pack_unpack_buffer_core.sv
tb/tb_bit_field_pack_unpack_buffer_core.sv
